// ===== src/u8sd_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam logic [20:0] REPL_CP      = 21'h00FFFD;
    localparam logic [7:0]  LEAD2_LO     = 8'hC2;
    localparam logic [7:0]  LEAD2_HI     = 8'hDF;
    localparam logic [7:0]  LEAD3_LO     = 8'hE0;
    localparam logic [7:0]  LEAD3_HI     = 8'hEF;
    localparam logic [7:0]  LEAD4_LO     = 8'hF0;
    localparam logic [7:0]  LEAD4_HI     = 8'hF4;
    localparam logic [7:0]  LEAD_E0      = 8'hE0;
    localparam logic [7:0]  LEAD_ED      = 8'hED;
    localparam logic [7:0]  LEAD_F0      = 8'hF0;
    localparam logic [7:0]  LEAD_F4      = 8'hF4;
    localparam logic [7:0]  E0_MIN_B1    = 8'hA0;
    localparam logic [7:0]  ED_MAX_B1    = 8'h9F;
    localparam logic [7:0]  F0_MIN_B1    = 8'h90;
    localparam logic [7:0]  F4_MAX_B1    = 8'h8F;
    localparam logic [7:0]  CONT_MASK    = 8'hC0;
    localparam logic [7:0]  CONT_TAG     = 8'h80;
    localparam logic [7:0]  PAYLOAD_MASK = 8'h3F;
    localparam int          MAX_RESULTS  = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       flush;
    } u8sd_in_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        malformed;
        logic [2:0]  byte_count;
        logic        last;
    } u8sd_out_t;

    typedef struct packed {
        u8sd_out_t [MAX_RESULTS-1:0] res;
        logic [2:0]                  count;
    } u8sd_burst_t;

    typedef struct packed {
        logic load_ok;
    } u8sd_queue_status_t;

endpackage

// ===== src/u8sd_decode.sv =====
// Sequence state and single-pass decode of one transaction into a result burst.
module u8sd_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  u8sd_pkg::u8sd_in_t    item,
    output u8sd_pkg::u8sd_burst_t burst
);
    import u8sd_pkg::*;

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] held_count_reg, held_count_next;
    logic [2:0] needed_reg, needed_next;

    logic [7:0]  b;
    logic        is_cont;
    logic        f_emit, f_hold;
    logic [2:0]  f_len;
    u8sd_out_t   f_res;
    logic [2:0]  n_full;
    logic [7:0]  b1;
    logic        seq_bad;
    logic [20:0] dec_cp;
    logic [2:0]  nb;
    logic        ex;
    u8sd_out_t   ex_res;

    assign b       = item.data_byte;
    assign is_cont = (b & CONT_MASK) == CONT_TAG;
    assign n_full  = {1'b0, held_count_reg} + 3'd1;
    assign b1      = (held_count_reg >= 2'd2) ? held_reg[1] : b;

    // byte with nothing held
    always_comb
    begin
        f_emit = 1'b0;
        f_hold = 1'b0;
        f_len  = 3'd0;
        f_res  = '0;
        if (b[7] == 1'b0)
        begin
            f_emit           = 1'b1;
            f_res.code_point = {13'd0, b};
            f_res.byte_count = 3'd1;
        end
        else if (b >= LEAD2_LO && b <= LEAD2_HI)
        begin
            f_hold = 1'b1;
            f_len  = 3'd2;
        end
        else if (b >= LEAD3_LO && b <= LEAD3_HI)
        begin
            f_hold = 1'b1;
            f_len  = 3'd3;
        end
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
        begin
            f_hold = 1'b1;
            f_len  = 3'd4;
        end
        else
        begin
            f_emit           = 1'b1;
            f_res.code_point = REPL_CP;
            f_res.malformed  = 1'b1;
            f_res.byte_count = 3'd1;
        end
    end

    always_comb
    begin
        seq_bad = 1'b0;
        if (n_full == 3'd3 && held_reg[0] == LEAD_E0 && b1 < E0_MIN_B1)
            seq_bad = 1'b1;
        if (n_full == 3'd3 && held_reg[0] == LEAD_ED && b1 > ED_MAX_B1)
            seq_bad = 1'b1;
        if (n_full == 3'd4 && held_reg[0] == LEAD_F0 && b1 < F0_MIN_B1)
            seq_bad = 1'b1;
        if (n_full == 3'd4 && held_reg[0] == LEAD_F4 && b1 > F4_MAX_B1)
            seq_bad = 1'b1;
    end

    always_comb
    begin
        unique case (held_count_reg)
            2'd1:    dec_cp = {10'd0, held_reg[0][4:0], b[5:0]};
            2'd2:    dec_cp = {5'd0, held_reg[0][3:0], held_reg[1][5:0], b[5:0]};
            default: dec_cp = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0], b[5:0]};
        endcase
    end

    always_comb
    begin
        nb              = 3'd0;
        ex              = 1'b0;
        ex_res          = '0;
        held_next       = held_reg;
        held_count_next = held_count_reg;
        needed_next     = needed_reg;
        if (item.flush)
        begin
            nb              = {1'b0, held_count_reg};
            held_count_next = 2'd0;
            needed_next     = 3'd0;
        end
        else if (held_count_reg != 2'd0 && is_cont)
        begin
            if (n_full < needed_reg)
            begin
                case (held_count_reg)
                    2'd1:    held_next[1] = b;
                    2'd2:    held_next[2] = b;
                    default: held_next[0] = held_reg[0];
                endcase
                held_count_next = n_full[1:0];
            end
            else
            begin
                held_count_next = 2'd0;
                needed_next     = 3'd0;
                if (seq_bad)
                    nb = n_full;
                else
                begin
                    ex                = 1'b1;
                    ex_res.code_point = dec_cp;
                    ex_res.byte_count = n_full;
                end
            end
        end
        else
        begin
            // nothing held, or held sequence broken by a non-continuation
            nb              = {1'b0, held_count_reg};
            held_count_next = 2'd0;
            needed_next     = 3'd0;
            ex              = f_emit;
            ex_res          = f_res;
            if (f_hold)
            begin
                held_next[0]    = b;
                held_count_next = 2'd1;
                needed_next     = f_len;
            end
        end
    end

    always_comb
    begin
        burst.count = nb + {2'd0, ex};
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (3'(i) < nb)
            begin
                burst.res[i]            = '0;
                burst.res[i].code_point = REPL_CP;
                burst.res[i].malformed  = 1'b1;
                burst.res[i].byte_count = 3'd1;
            end
            else if (3'(i) == nb && ex)
                burst.res[i] = ex_res;
            else
                burst.res[i] = '0;
            burst.res[i].last = (3'(i) + 3'd1 == burst.count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            needed_reg     <= 3'd0;
        end
        else if (advance)
        begin
            held_count_reg <= held_count_next;
            needed_reg     <= needed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            held_reg <= held_next;
    end

endmodule

// ===== src/u8sd_result_queue.sv =====
// Result register queue: holds one decoded burst; one transaction per cycle unless stalled.
module u8sd_result_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  u8sd_pkg::u8sd_burst_t        burst,
    output u8sd_pkg::u8sd_queue_status_t status,
    output logic                         cp_valid,
    input  logic                         cp_stall,
    output u8sd_pkg::u8sd_out_t          cp_item
);
    import u8sd_pkg::*;

    u8sd_out_t  q_reg [MAX_RESULTS];
    u8sd_out_t  q_next [MAX_RESULTS];
    logic [2:0] rem_reg, rem_next;
    logic       pop;

    assign cp_valid       = rem_reg != 3'd0;
    assign cp_item        = q_reg[0];
    assign pop            = cp_valid && !cp_stall;
    assign status.load_ok = (rem_reg == 3'd0) || (rem_reg == 3'd1 && pop);

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
                q_next[i] = burst.res[i];
            rem_next = burst.count;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                q_next[i] = q_reg[i+1];
            rem_next = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= 3'd0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

// ===== src/utf8_stream_decoder_core.sv =====
// Streaming UTF-8 decoder top level: input register, decode, result queue.
// A byte is captured in the input register, decoded combinationally, and its result burst is
// registered into the result queue, which presents it. Throughput: one byte per cycle while each
// byte yields at most one result and cp_stall is low; a burst of several results from one byte
// holds the input until the queue has presented all but its last result. Reset clears the
// held-sequence count, the input valid flag and the queue count; stored bytes and results stay.
module utf8_stream_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  u8sd_pkg::u8sd_in_t  byte_item,
    output logic                cp_valid,
    input  logic                cp_stall,
    output u8sd_pkg::u8sd_out_t cp_item
);
    import u8sd_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    u8sd_in_t           s1_item_reg;
    logic               accept;
    logic               advance;
    u8sd_burst_t        burst;
    u8sd_queue_status_t q_status;

    assign advance       = s1_valid_reg && q_status.load_ok;
    assign byte_stall    = s1_valid_reg && !q_status.load_ok;
    assign accept        = byte_valid && !byte_stall;
    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= byte_item;
    end

    u8sd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .burst   (burst)
    );

    u8sd_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .burst    (burst),
        .status   (q_status),
        .cp_valid (cp_valid),
        .cp_stall (cp_stall),
        .cp_item  (cp_item)
    );

endmodule
